FILE: rtl/set_assoc_cache_lru_controller_defines.svh
// Assertion helpers shared by the cache controller.
`ifndef SET_ASSOC_CACHE_LRU_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SACL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

   // Access kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Control register port
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_THROUGH  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_ALLOCATE = 8'd1;

   // Way numbers carried between lookup and top; covers up to 16 ways
   localparam int WAY_IDX_BITS = 4;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way_used;
      logic        fill_request;
      logic [31:0] fill_address;
      logic        writeback_request;
      logic [31:0] writeback_address;
      logic        write_forward;
   } rsp_type;

   typedef struct packed {
      logic                    hit;
      logic [WAY_IDX_BITS-1:0] hit_way;
      logic [WAY_IDX_BITS-1:0] victim_way;
   } lookup_type;

   function automatic int floor_log2(input int value);
      int n;
      int x;
      n = 0;
      x = value;
      while (x > 1) begin
         x = x >> 1;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sacl_ram.sv
`default_nettype none

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire                                          clock,
   input  wire                                          wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]                              wr_data,
   input  wire                                          rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/sacl_lookup.sv
`default_nettype none

module sacl_lookup #(
   parameter int WAYS  = 4,
   parameter int TAG_W = 20
) (
   input  wire [WAYS-1:0]             way_valid,
   input  wire [WAYS-1:0][TAG_W-1:0]  way_tag,
   input  wire [WAYS-1:0][31:0]       way_stamp,
   input  wire [TAG_W-1:0]            tag,
   output sacl_pkg::lookup_type       result
);

   localparam int IW     = sacl_pkg::WAY_IDX_BITS;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LEAVES = 1 << WAY_W;

   logic             hit;
   logic [IW-1:0]    hit_way;
   logic [31:0]      node_stamp [WAY_W+1][LEAVES];
   logic [WAY_W-1:0] node_idx   [WAY_W+1][LEAVES];
   logic             node_ok    [WAY_W+1][LEAVES];
   logic             take_right;

   // Lowest matching way wins: scan down so the last match kept is the lowest.
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (way_valid[i] && (way_tag[i] == tag)) begin
            hit     = 1'b1;
            hit_way = IW'(i);
         end
      end
   end

   // Oldest stamp by a compare tree; ties keep the left (lower) way.
   always_comb begin
      take_right = 1'b0;
      for (int l = 0; l <= WAY_W; l++) begin
         for (int n = 0; n < LEAVES; n++) begin
            node_stamp[l][n] = '0;
            node_idx[l][n]   = '0;
            node_ok[l][n]    = 1'b0;
         end
      end
      for (int n = 0; n < LEAVES; n++) begin
         if (n < WAYS) begin
            node_stamp[0][n] = way_stamp[n];
            node_idx[0][n]   = WAY_W'(n);
            node_ok[0][n]    = 1'b1;
         end
      end
      for (int l = 0; l < WAY_W; l++) begin
         for (int n = 0; n < (LEAVES >> (l + 1)); n++) begin
            take_right = node_ok[l][2*n+1] &&
                         (!node_ok[l][2*n] || (node_stamp[l][2*n+1] < node_stamp[l][2*n]));
            node_stamp[l+1][n] = take_right ? node_stamp[l][2*n+1] : node_stamp[l][2*n];
            node_idx[l+1][n]   = take_right ? node_idx[l][2*n+1]   : node_idx[l][2*n];
            node_ok[l+1][n]    = node_ok[l][2*n] || node_ok[l][2*n+1];
         end
      end
   end

   always_comb begin
      result.hit        = hit;
      result.hit_way    = hit_way;
      result.victim_way = IW'(node_idx[WAY_W][0]);
   end

endmodule

`default_nettype wire

FILE: rtl/set_assoc_cache_lru_controller.sv
// Response: registered; the set row read at accept is evaluated in the lookup state.
// Accesses: one at a time; no new request is taken until the read-modify-write of the
//   last one's set row in the tag/state RAM (read, then evaluate and write) is done.
// Reset: synchronous, active high; the RAM is then cleared one set per cycle,
//   all 2**floor(log2(SETS)) sets (64 at defaults), with req_ready low meanwhile.
`default_nettype none
`include "set_assoc_cache_lru_controller_defines.svh"

module set_assoc_cache_lru_controller #(
   parameter int SETS        = 64,
   parameter int WAYS        = 4,
   parameter int BLOCK_BYTES = 64,
   parameter int ADDR_BITS   = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire sacl_pkg::req_type               req_word,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output sacl_pkg::rsp_type                    rsp_word,
   // control register writes
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [sacl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [sacl_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   // ---------------------------------------------------------------------
   // Geometry. Offset and set widths round down for non-power-of-two sizes;
   // the address is cut to ADDR_BITS (at most the 32 bits of the port).
   // ---------------------------------------------------------------------
   localparam int OFF_W    = sacl_pkg::floor_log2(BLOCK_BYTES);
   localparam int SET_W    = sacl_pkg::floor_log2(SETS);
   localparam int EFF_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int TAG_RAW  = EFF_BITS - SET_W - OFF_W;
   localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int SET_IW   = (SET_W > 0) ? SET_W : 1;
   localparam int DEPTH    = 1 << SET_W;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W    = WAYS * (2 + TAG_W + 32);

   localparam logic [31:0] ADDR_MASK = 32'((64'd1 << EFF_BITS) - 64'd1);
   localparam logic [31:0] OFF_MASK  = 32'((64'd1 << OFF_W) - 64'd1);
   localparam logic [31:0] SET_MASK  = 32'((64'd1 << SET_W) - 64'd1);
   localparam logic [SET_IW-1:0] LAST_SET = SET_IW'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type          state_ff,  state_in;
   logic [SET_IW-1:0]  clr_ff,    clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sacl_pkg::rsp_type  rsp_ff,    rsp_in;
   logic [31:0]        counter_ff, counter_in;
   logic               write_through_ff,  write_through_in;
   logic               write_allocate_ff, write_allocate_in;
   // the access in flight
   logic               kind_ff,   kind_in;
   logic [31:0]        addr_ff,   addr_in;
   logic [SET_IW-1:0]  set_ff,    set_in;
   logic [TAG_W-1:0]   tag_ff,    tag_in;
   logic [31:0]        stamp_ff,  stamp_in;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   logic req_accept;
   logic rsp_accept;
   logic csr_accept;

   // Take a new word only between accesses and once the response slot is
   // free or being drained this cycle.
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;
   assign rsp_accept = rsp_valid_ff && rsp_ready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // ---------------------------------------------------------------------
   // Address split of the incoming word
   // ---------------------------------------------------------------------
   logic [31:0] req_addr_m;
   logic [31:0] req_set_full;
   logic [31:0] req_tag_full;

   assign req_addr_m   = req_word.address & ADDR_MASK;
   assign req_set_full = (req_addr_m >> OFF_W) & SET_MASK;
   assign req_tag_full = req_addr_m >> (SET_W + OFF_W);

   // ---------------------------------------------------------------------
   // Tag/state RAM: one row per set holding every way's valid, dirty, tag
   // and LRU stamp. Read at accept, written back in the lookup cycle.
   // Only one access is in flight, so no read can race a pending write.
   // ---------------------------------------------------------------------
   logic                     ram_wr_en;
   logic [SET_IW-1:0]        ram_wr_addr;
   logic [ROW_W-1:0]         ram_wr_data;
   logic [ROW_W-1:0]         ram_rd_data;

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_set_full[SET_IW-1:0]),
      .rd_data (ram_rd_data)
   );

   logic [WAYS-1:0]            row_valid;
   logic [WAYS-1:0]            row_dirty;
   logic [WAYS-1:0][TAG_W-1:0] row_tag;
   logic [WAYS-1:0][31:0]      row_stamp;

   assign {row_stamp, row_tag, row_dirty, row_valid} = ram_rd_data;

   // ---------------------------------------------------------------------
   // Hit detection and victim choice
   // ---------------------------------------------------------------------
   sacl_pkg::lookup_type lookup;

   sacl_lookup #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W)
   ) u_lookup (
      .way_valid (row_valid),
      .way_tag   (row_tag),
      .way_stamp (row_stamp),
      .tag       (tag_ff),
      .result    (lookup)
   );

   // ---------------------------------------------------------------------
   // Row update and response for the access in flight
   // ---------------------------------------------------------------------
   logic [WAYS-1:0]            new_valid;
   logic [WAYS-1:0]            new_dirty;
   logic [WAYS-1:0][TAG_W-1:0] new_tag;
   logic [WAYS-1:0][31:0]      new_stamp;
   logic [WAY_W-1:0]           hit_way;
   logic [WAY_W-1:0]           victim_way;
   logic [WAY_W-1:0]           way_sel;
   logic [31:0]                way_ext;
   logic                       is_write;
   sacl_pkg::rsp_type          result;

   assign hit_way    = lookup.hit_way[WAY_W-1:0];
   assign victim_way = lookup.victim_way[WAY_W-1:0];
   assign is_write   = (kind_ff == sacl_pkg::KIND_WRITE);

   always_comb begin
      new_valid = row_valid;
      new_dirty = row_dirty;
      new_tag   = row_tag;
      new_stamp = row_stamp;
      way_sel   = '0;
      result    = '0;

      if (lookup.hit) begin
         // Hit: refresh the stamp; a write either dirties or goes below.
         way_sel            = hit_way;
         result.hit         = 1'b1;
         new_stamp[hit_way] = stamp_ff;
         if (is_write) begin
            if (write_through_ff) begin
               result.write_forward = 1'b1;
            end else begin
               new_dirty[hit_way] = 1'b1;
            end
         end
      end else if (is_write && !write_allocate_ff) begin
         // Write miss without allocation: forward only, row untouched.
         result.write_forward = 1'b1;
      end else begin
         // Allocate: evict the oldest way, writing it back if dirty.
         way_sel = victim_way;
         if (row_valid[victim_way] && row_dirty[victim_way]) begin
            result.writeback_request = 1'b1;
            result.writeback_address =
               ((32'(row_tag[victim_way]) << (SET_W + OFF_W)) | (32'(set_ff) << OFF_W))
               & ADDR_MASK;
         end
         result.fill_request   = 1'b1;
         result.fill_address   = addr_ff & ~OFF_MASK;
         new_valid[victim_way] = 1'b1;
         new_tag[victim_way]   = tag_ff;
         new_stamp[victim_way] = stamp_ff;
         new_dirty[victim_way] = is_write;
      end

      way_ext         = 32'(way_sel);
      result.way_used = way_ext[1:0];
   end

   // RAM write port: zero rows during the clearing pass, the updated row
   // in the lookup cycle.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = set_ff;
      ram_wr_data = {new_stamp, new_tag, new_dirty, new_valid};
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         ST_LOOKUP: begin
            ram_wr_en = 1'b1;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_in            = rsp_ff;
      counter_in        = counter_ff;
      write_through_in  = write_through_ff;
      write_allocate_in = write_allocate_ff;
      kind_in           = kind_ff;
      addr_in           = addr_ff;
      set_in            = set_ff;
      tag_in            = tag_ff;
      stamp_in          = stamp_ff;

      // Drop the response once taken; a new one only lands in the lookup cycle.
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end

      // Only bit 0 of the data counts; unknown indexes are dropped.
      if (csr_accept) begin
         case (csr_index)
            sacl_pkg::CSR_WRITE_THROUGH:  write_through_in  = csr_data[0];
            sacl_pkg::CSR_WRITE_ALLOCATE: write_allocate_in = csr_data[0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_IW'(1);
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               // Advance the access counter; its new value is this access's stamp.
               counter_in = counter_ff + 32'd1;
               stamp_in   = counter_ff + 32'd1;
               kind_in    = req_word.kind;
               addr_in    = req_addr_m;
               set_in     = req_set_full[SET_IW-1:0];
               tag_in     = req_tag_full[TAG_W-1:0];
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload: no reset needed
      rsp_ff   <= rsp_in;
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      set_ff   <= set_in;
      tag_ff   <= tag_in;
      stamp_ff <= stamp_in;
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
         counter_ff        <= '0;
         write_through_ff  <= 1'b0;
         write_allocate_ff <= 1'b1;
      end else begin
         state_ff          <= state_in;
         clr_ff            <= clr_in;
         rsp_valid_ff      <= rsp_valid_in;
         counter_ff        <= counter_in;
         write_through_ff  <= write_through_in;
         write_allocate_ff <= write_allocate_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `SACL_ASSERT_NOW(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, !req_ready,
      "request taken during the RAM clearing pass")
   `SACL_ASSERT_NEXT(a_accept_to_lookup, clock, reset, req_accept, state_ff == ST_LOOKUP,
      "accepted access did not enter lookup")
   `SACL_ASSERT_NEXT(a_lookup_to_rsp, clock, reset, state_ff == ST_LOOKUP, rsp_valid_ff,
      "lookup did not produce a response")
   `SACL_ASSERT_NOW(a_rsp_consistent, clock, reset, rsp_valid_ff,
      !(rsp_ff.fill_request && (rsp_ff.hit || rsp_ff.write_forward)),
      "fill reported together with a hit or a forwarded write")

endmodule

`default_nettype wire
